### rtl/lru_cache_with_ttl_assert.svh
// Assertion macros shared by the cache RTL.
// Expects signals named clk and arst_n in the including scope.
`ifndef LRU_CACHE_WITH_TTL_ASSERT_SVH
`define LRU_CACHE_WITH_TTL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lct_pkg.sv
// Shared types and codes for the LRU cache with expiry.
// No dependencies; used by lct_ctrl, lct_dpath and lru_cache_with_ttl.
`timescale 1ns / 1ps

package lct_pkg;

	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		CMD_GET    = 2'd0,
		CMD_PUT    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	localparam logic [3:0] ST_MISS     = 4'd0;
	localparam logic [3:0] ST_HIT      = 4'd1;
	localparam logic [3:0] ST_EXPIRED  = 4'd2;
	localparam logic [3:0] ST_INSERTED = 4'd3;
	localparam logic [3:0] ST_UPDATED  = 4'd4;
	localparam logic [3:0] ST_EVICTED  = 4'd5;
	localparam logic [3:0] ST_REMOVED  = 4'd6;
	localparam logic [3:0] ST_ABSENT   = 4'd7;
	localparam logic [3:0] ST_TICKED   = 4'd8;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] key;
		logic [31:0] value_in;
		logic [15:0] ttl_seconds;
	} req_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] value_out;
		logic [31:0] evicted_key;
	} rsp_t;

	typedef enum logic [1:0] {
		RM_NONE,
		RM_DEC,
		RM_PROMOTE,
		RM_INC
	} rank_mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_DECIDE,
		S_RANK,
		S_COMMIT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic idle;
		logic start;
		logic sweep;
		logic rank_phase;
		logic decide;
		logic commit;
		logic respond;
	} ctl_t;

	typedef struct packed {
		logic req_valid;
		logic req_tick;
		logic sweep_done;
		logic need_rank;
		logic out_free;
	} stat_t;

endpackage

### rtl/lct_ctrl.sv
// Sequencer for the cache: search sweep, decision, rank sweep, commit, reply.
// Depends on lct_pkg.
`timescale 1ns / 1ps

module lct_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  lct_pkg::stat_t st,
	output lct_pkg::ctl_t  ctl
);
	import lct_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		ctl = '0;
		case (state_q)
			S_IDLE: begin
				ctl.idle = 1'b1;
				if (st.req_valid) begin
					ctl.start = 1'b1;
					// a tick touches no entry: skip the search
					state_nxt = st.req_tick ? S_DECIDE : S_SEARCH;
				end
			end
			S_SEARCH: begin
				ctl.sweep = 1'b1;
				if (st.sweep_done) begin
					state_nxt = S_DECIDE;
				end
			end
			S_DECIDE: begin
				ctl.decide = 1'b1;
				state_nxt = st.need_rank ? S_RANK : S_COMMIT;
			end
			S_RANK: begin
				ctl.sweep = 1'b1;
				ctl.rank_phase = 1'b1;
				if (st.sweep_done) begin
					state_nxt = S_COMMIT;
				end
			end
			S_COMMIT: begin
				ctl.commit = 1'b1;
				state_nxt = S_RESP;
			end
			S_RESP: begin
				ctl.respond = 1'b1;
				if (st.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

### rtl/lct_dpath.sv
// Datapath for the cache: entry memories, valid bits, sweep pipeline,
// decision logic, capacity register and reply register. Depends on lct_pkg.
`timescale 1ns / 1ps

module lct_dpath #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32,
	parameter int TIME_BITS  = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lct_pkg::ctl_t  ctl,
	output lct_pkg::stat_t st,
	input  logic           req_valid,
	input  lct_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output lct_pkg::rsp_t  rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import lct_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

	typedef struct packed {
		logic [KW-1:0]        key;
		logic [VW-1:0]        value;
		logic [TIME_BITS-1:0] expiry;
	} kv_t;

	kv_t                  kv_mem [ENTRIES];
	logic [IW-1:0]        rank_mem [ENTRIES];

	logic [CAP_W-1:0]     cap_q;
	logic [TIME_BITS-1:0] time_q;
	req_t                 req_q;
	logic [ENTRIES-1:0]   valid_q;
	logic [CW-1:0]        idx_q;

	logic                 rd_vld_s1;
	logic [IW-1:0]        rd_idx_s1;
	kv_t                  kv_s1;
	logic [IW-1:0]        rank_s1;

	logic [CW-1:0]        cnt_q;
	logic                 hit_q;
	logic [IW-1:0]        hit_idx_q;
	logic [IW-1:0]        hit_rank_q;
	logic [VW-1:0]        hit_val_q;
	logic [TIME_BITS-1:0] hit_exp_q;
	logic                 vic_found_q;
	logic [IW-1:0]        vic_idx_q;
	logic [IW-1:0]        vic_rank_q;
	logic [KW-1:0]        vic_key_q;
	logic                 free_found_q;
	logic [IW-1:0]        free_idx_q;

	rank_mode_t           mode_q;
	logic [IW-1:0]        r_q;
	logic [IW-1:0]        s_q;
	logic                 kvwr_q;
	logic                 new_q;
	logic [IW-1:0]        widx_q;
	logic [TIME_BITS-1:0] exp_q;
	rsp_t                 rsp_n_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	logic                 issue;
	logic [IW-1:0]        raddr;
	logic                 v1;
	logic                 out_free;
	logic [KW-1:0]        req_key;
	logic [VW-1:0]        req_val;

	// decision outputs
	logic [3:0]           d_status;
	logic [VW-1:0]        d_vout;
	logic [KW-1:0]        d_ekey;
	rank_mode_t           d_mode;
	logic [IW-1:0]        d_r;
	logic                 d_clr;
	logic [IW-1:0]        d_clr_idx;
	logic                 d_kvwr;
	logic                 d_new;
	logic [IW-1:0]        d_widx;
	logic [TIME_BITS-1:0] d_exp;

	// rank sweep write
	logic                 rk_w;
	logic [IW-1:0]        rk_new;
	logic                 rank_we;
	logic [IW-1:0]        rank_wa;
	logic [IW-1:0]        rank_wd;

	assign req_key  = req_q.key[KW-1:0];
	assign req_val  = req_q.value_in[VW-1:0];
	assign issue    = ctl.sweep && (idx_q != CW'(ENTRIES));
	assign raddr    = idx_q[IW-1:0];
	assign v1       = valid_q[rd_idx_s1];
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign st.req_valid  = req_valid;
	assign st.req_tick   = (req.command == CMD_TICK);
	assign st.sweep_done = ctl.sweep && (idx_q == CW'(ENTRIES)) && !rd_vld_s1;
	assign st.need_rank  = (d_mode != RM_NONE);
	assign st.out_free   = out_free;

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;
	assign prdata    = 32'(cap_q);
	assign pready    = 1'b1;

	// memories
	always_ff @(posedge clk) begin
		if (issue) begin
			kv_s1     <= kv_mem[raddr];
			rank_s1   <= rank_mem[raddr];
			rd_idx_s1 <= raddr;
		end
		if (ctl.commit && kvwr_q) begin
			kv_mem[widx_q] <= '{key: req_key, value: req_val, expiry: exp_q};
		end
		if (rank_we) begin
			rank_mem[rank_wa] <= rank_wd;
		end
	end

	// new rank of the entry coming out of the sweep pipeline
	always_comb begin
		rk_w = 1'b0;
		rk_new = rank_s1;
		case (mode_q)
			RM_DEC: begin
				if (rank_s1 > r_q) begin
					rk_w = 1'b1;
					rk_new = rank_s1 - IW'(1);
				end
			end
			RM_PROMOTE: begin
				if (rd_idx_s1 == s_q) begin
					rk_w = 1'b1;
					rk_new = '0;
				end else if (rank_s1 < r_q) begin
					rk_w = 1'b1;
					rk_new = rank_s1 + IW'(1);
				end
			end
			RM_INC: begin
				rk_w = 1'b1;
				rk_new = rank_s1 + IW'(1);
			end
			default: begin
				rk_w = 1'b0;
			end
		endcase
		rk_w = rk_w && rd_vld_s1 && ctl.rank_phase && v1;

		rank_we = rk_w || (ctl.commit && new_q);
		rank_wa = rk_w ? rd_idx_s1 : widx_q;
		rank_wd = rk_w ? rk_new : '0;
	end

	// decision on the search results
	always_comb begin
		logic [TIME_BITS:0] sum;
		int unsigned        capi;
		logic               evict;

		sum = {1'b0, time_q} + (TIME_BITS + 1)'(req_q.ttl_seconds);
		d_exp = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
		if (cap_q == '0) begin
			capi = 1;
		end else if (int'(cap_q) > ENTRIES) begin
			capi = ENTRIES;
		end else begin
			capi = int'(cap_q);
		end
		evict = (cnt_q != '0) && (int'(cnt_q) >= capi);

		d_status  = ST_MISS;
		d_vout    = '0;
		d_ekey    = '0;
		d_mode    = RM_NONE;
		d_r       = hit_rank_q;
		d_clr     = 1'b0;
		d_clr_idx = hit_idx_q;
		d_kvwr    = 1'b0;
		d_new     = 1'b0;
		d_widx    = hit_idx_q;
		case (req_q.command)
			CMD_GET: begin
				if (!hit_q) begin
					d_status = ST_MISS;
				end else if (time_q >= hit_exp_q) begin
					d_status = ST_EXPIRED;
					d_clr = 1'b1;
					d_mode = RM_DEC;
				end else begin
					d_status = ST_HIT;
					d_vout = hit_val_q;
					d_mode = RM_PROMOTE;
				end
			end
			CMD_PUT: begin
				d_kvwr = 1'b1;
				if (hit_q) begin
					d_status = ST_UPDATED;
					d_mode = RM_PROMOTE;
				end else begin
					d_new = 1'b1;
					d_mode = RM_INC;
					if (evict) begin
						d_status = ST_EVICTED;
						d_ekey = vic_key_q;
						d_clr = 1'b1;
						d_clr_idx = vic_idx_q;
						// the freed victim slot may be the lowest free one
						d_widx = (!free_found_q || vic_idx_q < free_idx_q) ?
							vic_idx_q : free_idx_q;
					end else begin
						d_status = ST_INSERTED;
						d_widx = free_idx_q;
					end
				end
			end
			CMD_REMOVE: begin
				if (hit_q) begin
					d_status = ST_REMOVED;
					d_clr = 1'b1;
					d_mode = RM_DEC;
				end else begin
					d_status = ST_ABSENT;
				end
			end
			default: begin
				d_status = ST_TICKED;
			end
		endcase
		if (!ctl.decide) begin
			d_mode = RM_NONE;
		end
	end

	// payload registers of the current item
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			req_q <= req;
		end
		if (rd_vld_s1 && !ctl.rank_phase && v1) begin
			if (kv_s1.key == req_key) begin
				hit_idx_q  <= rd_idx_s1;
				hit_rank_q <= rank_s1;
				hit_val_q  <= kv_s1.value;
				hit_exp_q  <= kv_s1.expiry;
			end
			if (!vic_found_q || rank_s1 > vic_rank_q) begin
				vic_idx_q  <= rd_idx_s1;
				vic_rank_q <= rank_s1;
				vic_key_q  <= kv_s1.key;
			end
		end
		if (rd_vld_s1 && !ctl.rank_phase && !v1 && !free_found_q) begin
			free_idx_q <= rd_idx_s1;
		end
		if (ctl.decide) begin
			mode_q  <= d_mode;
			r_q     <= d_r;
			s_q     <= hit_idx_q;
			kvwr_q  <= d_kvwr;
			new_q   <= d_new;
			widx_q  <= d_widx;
			exp_q   <= d_exp;
			rsp_n_q <= '{status: d_status, value_out: 32'(d_vout),
				evicted_key: 32'(d_ekey)};
		end
		if (ctl.respond && out_free) begin
			rsp_q <= rsp_n_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CAP_RESET;
			time_q       <= '0;
			valid_q      <= '0;
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			cnt_q        <= '0;
			hit_q        <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				cap_q <= pwdata[CAP_W-1:0];
			end
			rd_vld_s1 <= issue;
			if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			if (ctl.start) begin
				idx_q        <= '0;
				cnt_q        <= '0;
				hit_q        <= 1'b0;
				vic_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (rd_vld_s1 && !ctl.rank_phase) begin
				if (v1) begin
					cnt_q <= cnt_q + CW'(1);
					vic_found_q <= 1'b1;
					if (kv_s1.key == req_key) begin
						hit_q <= 1'b1;
					end
				end else begin
					free_found_q <= 1'b1;
				end
			end
			if (ctl.decide) begin
				idx_q <= '0;
				if (d_clr) begin
					valid_q[d_clr_idx] <= 1'b0;
				end
				// saturate the seconds counter
				if (req_q.command == CMD_TICK && time_q != '1) begin
					time_q <= time_q + TIME_BITS'(1);
				end
			end
			if (ctl.commit && new_q) begin
				valid_q[widx_q] <= 1'b1;
			end
			if (ctl.respond && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/lru_cache_with_ttl.sv
// Fully associative LRU cache with per-entry expiry: get, put, remove, tick.
// One request at a time. Get, put and remove sweep all ENTRIES slots once to
// search (one memory read a cycle; the last read lands and the pipeline
// drains), take a decision state, sweep again to re-rank when the recency
// order changes, then commit and load the reply register. A tick skips both
// sweeps. The reply state waits for the previous reply to leave. Capacity
// is written over the APB-style port, where every address decodes to it.
// The user writes it only while the block is idle; the block itself does not
// enforce this. Depends on lct_pkg, lct_ctrl, lct_dpath and
// lru_cache_with_ttl_assert.svh.
`timescale 1ns / 1ps
`include "lru_cache_with_ttl_assert.svh"

module lru_cache_with_ttl #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32,
	parameter int TIME_BITS  = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lct_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lct_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [1:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import lct_pkg::*;

	ctl_t  ctl;
	stat_t st;
	logic  cfg_hit;

	// single register: every address decodes to capacity
	assign cfg_hit = (paddr == paddr);

	lct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctl    (ctl)
	);

	lct_dpath #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.st        (st),
		.req_valid (req_valid),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel && cfg_hit),
		.penable   (penable),
		.pwrite    (pwrite),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	assign req_stall = !ctl.idle;

	`LCT_ASSERT_NXT(a_one_item, req_valid && !req_stall, req_stall, "second beat taken mid-op")
	`LCT_ASSERT_NXT(a_reply_loaded, ctl.respond && st.out_free, rsp_valid, "reply not loaded")
	`LCT_ASSERT_IMP(a_status_range, rsp_valid, rsp.status <= ST_TICKED, "reply status out of range")

endmodule

### tb/tb_top.sv
// Self-checking bench for lru_cache_with_ttl: directed and random get/put/remove/tick beats
// checked against a behavioural cache model. Depends on lct_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
	import lct_pkg::*;

	localparam int NSLOT = 16;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	lru_cache_with_ttl dut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// cache model state
	bit mdl_valid [NSLOT];
	bit [31:0] mdl_key [NSLOT];
	bit [31:0] mdl_val [NSLOT];
	bit [31:0] mdl_exp [NSLOT];
	int mdl_rank [NSLOT];
	bit [31:0] mdl_now;
	int mdl_cap;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;
	int hold_left = 0;
	int drv_gap = 0, mon_gap = 0;
	bit [31:0] key_pool [8];

	function automatic int find_slot(bit [31:0] k);
		for (int i = 0; i < NSLOT; i++)
			if (mdl_valid[i] && mdl_key[i] == k) return i;
		return -1;
	endfunction

	function automatic void drop_slot(int s);
		int r;
		r = mdl_rank[s];
		mdl_valid[s] = 1'b0;
		for (int i = 0; i < NSLOT; i++)
			if (mdl_valid[i] && mdl_rank[i] > r) mdl_rank[i]--;
	endfunction

	function automatic void promote_slot(int s);
		int r;
		r = mdl_rank[s];
		for (int i = 0; i < NSLOT; i++)
			if (mdl_valid[i] && mdl_rank[i] < r) mdl_rank[i]++;
		mdl_rank[s] = 0;
	endfunction

	function automatic rsp_t cache_outcome(req_t r);
		rsp_t o;
		int s, n, c;
		bit [32:0] sum;
		bit [31:0] ex;
		o = '0;
		s = find_slot(r.key);
		case (cmd_t'(r.command))
			CMD_GET: begin
				if (s < 0) o.status = ST_MISS;
				else if (mdl_now >= mdl_exp[s]) begin
					drop_slot(s);
					o.status = ST_EXPIRED;
				end else begin
					promote_slot(s);
					o.value_out = mdl_val[s];
					o.status = ST_HIT;
				end
			end
			CMD_PUT: begin
				sum = {1'b0, mdl_now} + 33'(r.ttl_seconds);
				ex = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				if (s >= 0) begin
					mdl_val[s] = r.value_in;
					mdl_exp[s] = ex;
					promote_slot(s);
					o.status = ST_UPDATED;
				end else begin
					n = 0;
					foreach (mdl_valid[i]) if (mdl_valid[i]) n++;
					c = (mdl_cap == 0) ? 1 : (mdl_cap > NSLOT ? NSLOT : mdl_cap);
					o.status = ST_INSERTED;
					if (n > 0 && n >= c) begin
						for (int i = 0; i < NSLOT; i++)
							if (mdl_valid[i] && mdl_rank[i] == n - 1) begin
								o.evicted_key = mdl_key[i];
								drop_slot(i);
								o.status = ST_EVICTED;
								break;
							end
					end
					for (int i = 0; i < NSLOT; i++) if (mdl_valid[i]) mdl_rank[i]++;
					for (int i = 0; i < NSLOT; i++)
						if (!mdl_valid[i]) begin
							mdl_valid[i] = 1'b1;
							mdl_key[i] = r.key;
							mdl_val[i] = r.value_in;
							mdl_exp[i] = ex;
							mdl_rank[i] = 0;
							break;
						end
				end
			end
			CMD_REMOVE: begin
				if (s >= 0) begin
					drop_slot(s);
					o.status = ST_REMOVED;
				end else o.status = ST_ABSENT;
			end
			default: begin
				if (mdl_now != 32'hFFFF_FFFF) mdl_now++;
				o.status = ST_TICKED;
			end
		endcase
		return o;
	endfunction

	function automatic req_t make_req(cmd_t c, bit [31:0] k, bit [31:0] v, bit [15:0] t);
		req_t r;
		r.command = c;
		r.key = k;
		r.value_in = v;
		r.ttl_seconds = t;
		return r;
	endfunction

	// mostly keys from a small pool so hits, updates and expiries happen
	function automatic req_t random_req();
		cmd_t c;
		bit [31:0] k;
		bit [15:0] t;
		int p;
		p = $urandom_range(99);
		c = p < 35 ? CMD_GET : p < 75 ? CMD_PUT : p < 88 ? CMD_REMOVE : CMD_TICK;
		k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(7)];
		case ($urandom_range(3))
			0: t = 16'($urandom());
			1: t = 16'hFFFF;
			default: t = 16'($urandom_range(4));
		endcase
		return make_req(c, k, $urandom(), t);
	endfunction

	// sample after the clock edge has settled so an in-flight beat is never missed
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(negedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_capacity(bit [31:0] v);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		mdl_cap = v & 31;
	endtask

	// driver: present one pending beat at a time, hold it while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				void'(pending_reqs.pop_front());
				if (!calm && $urandom_range(5) == 0) drv_gap = $urandom_range(1, 18);
			end
			if (req_valid && req_stall) begin
			end else if (drv_gap > 0) begin
				drv_gap--;
				req_valid <= 1'b0;
			end else if ((req_valid && !req_stall ? pending_reqs.size() > 0 :
					pending_reqs.size() > 0)) begin
				req_valid <= 1'b1;
				req <= pending_reqs[0];
			end else req_valid <= 1'b0;
		end
	end

	// receiver stall bursts; a long hold-off is counted down here
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (mon_gap > 0) begin
				mon_gap--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				if (!calm && $urandom_range(7) == 0) mon_gap = $urandom_range(1, 18);
			end
		end
	end

	// monitor: predict on accepted request beats, compare on response beats
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (req_valid && !req_stall) begin
				expected_rsps.push_back(cache_outcome(req));
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected response beat %p", rsp);
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.status !== want.status || rsp.value_out !== want.value_out ||
							rsp.evicted_key !== want.evicted_key) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected st=%0d val=%h ev=%h got st=%0d val=%h ev=%h",
								want.status, want.value_out, want.evicted_key,
								rsp.status, rsp.value_out, rsp.evicted_key);
					end
				end
			end
			if (idle_cycles >= WATCHDOG) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int caps [6];
		for (int i = 0; i < NSLOT; i++) begin
			mdl_valid[i] = 1'b0;
			mdl_rank[i] = 0;
		end
		mdl_now = '0;
		mdl_cap = 16;
		foreach (key_pool[i]) key_pool[i] = $urandom();
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFFF;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every command, expiry, capacity
		write_capacity(32'd2);
		pending_reqs.push_back(make_req(CMD_GET, 32'h0, 32'h0, 16'h0));
		pending_reqs.push_back(make_req(CMD_PUT, 32'h0, 32'hFFFF_FFFF, 16'h0));
		pending_reqs.push_back(make_req(CMD_GET, 32'h0, 32'h0, 16'h0));
		pending_reqs.push_back(make_req(CMD_PUT, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 16'hFFFF));
		pending_reqs.push_back(make_req(CMD_PUT, 32'h0, 32'h1234_5678, 16'd1));
		pending_reqs.push_back(make_req(CMD_GET, 32'h0, 32'h0, 16'h0));
		pending_reqs.push_back(make_req(CMD_PUT, 32'h5555_AAAA, 32'h1, 16'd2));
		pending_reqs.push_back(make_req(CMD_TICK, 32'h0, 32'h0, 16'h0));
		pending_reqs.push_back(make_req(CMD_GET, 32'h0, 32'h0, 16'h0));
		pending_reqs.push_back(make_req(CMD_GET, 32'h5555_AAAA, 32'h0, 16'h0));
		pending_reqs.push_back(make_req(CMD_REMOVE, 32'h5555_AAAA, 32'h0, 16'h0));
		pending_reqs.push_back(make_req(CMD_REMOVE, 32'h5555_AAAA, 32'h0, 16'h0));
		pending_reqs.push_back(make_req(CMD_PUT, 32'hFFFF_FFFF, 32'h0, 16'h0));
		pending_reqs.push_back(make_req(CMD_GET, 32'hFFFF_FFFF, 32'h0, 16'h0));
		wait_drained();
		write_capacity(32'd0);
		pending_reqs.push_back(make_req(CMD_PUT, 32'hAAAA_5555, 32'h2, 16'hFFFF));
		pending_reqs.push_back(make_req(CMD_PUT, 32'h3, 32'h3, 16'hFFFF));
		wait_drained();

		caps = '{31, 1, 16, 5, 17, 3};
		foreach (caps[ph]) begin
			write_capacity(caps[ph]);
			if (ph == 2) begin
				// long receiver hold-off while requests keep coming
				hold_left = 400;
				repeat (30) pending_reqs.push_back(random_req());
				wait (hold_left == 0);
			end
			if (ph == 5) calm = 1'b1;
			repeat (260) pending_reqs.push_back(random_req());
			wait_drained();
		end
		if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
